// ===== sv/glbr_pkg.sv =====
// shared types and codes for the gauss lattice basis reduction core
`timescale 1ns / 1ps

package glbr_pkg;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DUV0,
		S_NEG,
		S_DUU,
		S_DVV,
		S_ORD,
		S_RUV,
		S_DIV0,
		S_DIV,
		S_QFIX,
		S_UPD,
		S_ROT,
		S_RVV,
		S_LOOP,
		S_CUV,
		S_CSEL,
		S_CTT,
		S_CFIN,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DOT,
		OP_NEGV,
		OP_SWAP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_QFIX,
		OP_UPD,
		OP_ROT,
		OP_SETLIM,
		OP_TDIFF,
		OP_FIN_A,
		OP_FIN_B,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		DOT_UV,
		DOT_UU,
		DOT_VV,
		DOT_TT
	} dsel_t;

	typedef struct packed {
		op_t         op;
		dsel_t       dsel;
		logic [1:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic uv_neg;
		logic uu_lt_vv;
		logic vv_lt_uu;
		logic d2_lt_vv;
		logic vv_lt_tt;
	} flags_t;

	localparam logic [1:0] ST_REDUCED = 2'd0;
	localparam logic [1:0] ST_LIMIT   = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

endpackage

// ===== sv/glbr_ctrl.sv =====
// sequencer for the reduction rounds and the output beat
`timescale 1ns / 1ps

module glbr_ctrl import glbr_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int MAX_ROUNDS = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	output logic   m_tvalid,
	input  logic   m_tready,
	input  flags_t flags,
	output cmd_t   cmd
);

	localparam int CNT_W = $clog2(COORD_BITS);
	localparam int RW    = $clog2(MAX_ROUNDS + 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [RW-1:0]    rounds_q;
	logic             m_valid_q;
	logic             dot_last;
	logic             div_last;
	logic             out_free;

	assign dot_last = (cnt_q == CNT_W'(3));
	assign div_last = (cnt_q == CNT_W'(COORD_BITS - 1));
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_DUV0;
			S_DUV0: if (dot_last) state_d = S_NEG;
			S_NEG:  state_d = S_DUU;
			S_DUU:  if (dot_last) state_d = S_DVV;
			S_DVV:  if (dot_last) state_d = S_ORD;
			S_ORD:  state_d = S_RUV;
			S_RUV:  if (dot_last) state_d = S_DIV0;
			S_DIV0: state_d = S_DIV;
			S_DIV:  if (div_last) state_d = S_QFIX;
			S_QFIX: state_d = S_UPD;
			S_UPD:  if (dot_last) state_d = S_ROT;
			S_ROT:  state_d = S_RVV;
			S_RVV:  if (dot_last) state_d = S_LOOP;
			S_LOOP: begin
				if (flags.vv_lt_uu && (rounds_q < RW'(MAX_ROUNDS))) state_d = S_RUV;
				else state_d = S_CUV;
			end
			S_CUV:  if (dot_last) state_d = S_CSEL;
			S_CSEL: begin
				if (flags.d2_lt_vv) state_d = S_OUT;
				else state_d = S_CTT;
			end
			S_CTT:  if (dot_last) state_d = S_CFIN;
			S_CFIN: state_d = S_OUT;
			S_OUT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NOP;
		cmd.dsel = DOT_UV;
		cmd.idx  = cnt_q[1:0];
		unique case (state_q)
			S_IDLE: if (s_tvalid) cmd.op = OP_LOAD;
			S_DUV0: cmd.op = OP_DOT;
			S_NEG:  if (flags.uv_neg) cmd.op = OP_NEGV;
			S_DUU: begin
				cmd.op   = OP_DOT;
				cmd.dsel = DOT_UU;
			end
			S_DVV: begin
				cmd.op   = OP_DOT;
				cmd.dsel = DOT_VV;
			end
			S_ORD:  if (flags.uu_lt_vv) cmd.op = OP_SWAP;
			S_RUV:  cmd.op = OP_DOT;
			S_DIV0: cmd.op = OP_DIV_INIT;
			S_DIV:  cmd.op = OP_DIV_STEP;
			S_QFIX: cmd.op = OP_QFIX;
			S_UPD:  cmd.op = OP_UPD;
			S_ROT:  cmd.op = OP_ROT;
			S_RVV: begin
				cmd.op   = OP_DOT;
				cmd.dsel = DOT_VV;
			end
			S_LOOP: begin
				if (!(flags.vv_lt_uu && (rounds_q < RW'(MAX_ROUNDS)))) cmd.op = OP_SETLIM;
			end
			S_CUV:  cmd.op = OP_DOT;
			S_CSEL: begin
				if (flags.d2_lt_vv) cmd.op = OP_SWAP;
				else cmd.op = OP_TDIFF;
			end
			S_CTT: begin
				cmd.op   = OP_DOT;
				cmd.dsel = DOT_TT;
			end
			S_CFIN: begin
				if (flags.vv_lt_tt) cmd.op = OP_FIN_A;
				else cmd.op = OP_FIN_B;
			end
			S_OUT:  if (out_free) cmd.op = OP_OUT;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rounds_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + CNT_W'(1);
			if (state_q == S_ORD) rounds_q <= '0;
			else if (state_q == S_ROT) rounds_q <= rounds_q + RW'(1);
			if (state_q == S_OUT && out_free) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	a_rounds_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rounds_q <= RW'(MAX_ROUNDS))
		else $error("round count past limit");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("accepted a beat while busy");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (m_tvalid && state_q == S_IDLE))
		else $error("result not presented after load");

	a_dot_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DOT || cmd.op == OP_UPD) |-> cnt_q <= CNT_W'(3))
		else $error("dot step counter overran");

endmodule

// ===== sv/glbr_dp.sv =====
// datapath: vectors, dot product mac, quotient divider and clamping
`timescale 1ns / 1ps

module glbr_dp import glbr_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	input  logic signed [COORD_BITS-1:0] in_a [3],
	input  logic signed [COORD_BITS-1:0] in_b [3],
	output flags_t                       flags,
	output logic signed [COORD_BITS-1:0] res_u [3],
	output logic signed [COORD_BITS-1:0] res_v [3],
	output logic [1:0]                   res_status
);

	localparam int C   = COORD_BITS;
	localparam int MW  = C + 2;
	localparam int PW  = 2 * MW;
	localparam int DW  = PW;
	localparam int QW  = C + 2;
	localparam int XW  = DW + C - 1;
	localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
	localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

	logic signed [C-1:0]  u_q [3];
	logic signed [C-1:0]  v_q [3];
	logic signed [C:0]    t_q [3];
	logic signed [DW-1:0] uu_q, vv_q, uv_q, tt_q, acc_q;
	logic signed [PW-1:0] prod_s1;
	logic [DW-1:0]        r_q;
	logic [XW-1:0]        ds_q;
	logic [C-1:0]         qmag_q;
	logic                 neg_q, ovf_q, zero_q;
	logic signed [QW-1:0] q_q;
	logic                 sat_q, lim_q;
	logic signed [C-1:0]  res_u_q [3];
	logic signed [C-1:0]  res_v_q [3];
	logic [1:0]           res_st_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [DW-1:0] dot_sum;
	logic [1:0]           k2, kp;
	logic [C:0]           upd_cl;
	logic [DW-1:0]        mag;
	logic                 ge;
	logic [C:0]           qm;
	logic signed [QW-1:0] qpos, qval;
	logic [C:0]           negc [3];
	logic [C:0]           tcl [3];

	function automatic logic [C:0] clampc(input logic signed [PW:0] x);
		logic signed [PW:0] hi, lo;
		logic [C:0] r;
		hi = (PW+1)'(CMAX);
		lo = (PW+1)'(CMIN);
		if (x < lo) r = {1'b1, CMIN};
		else if (x > hi) r = {1'b1, CMAX};
		else r = {1'b0, x[C-1:0]};
		return r;
	endfunction

	assign k2 = (cmd.idx == 2'd3) ? 2'd0 : cmd.idx;
	assign kp = (cmd.idx == 2'd0) ? 2'd0 : cmd.idx - 2'd1;

	always_comb begin
		mul_a = MW'(u_q[k2]);
		mul_b = MW'(v_q[k2]);
		if (cmd.op == OP_UPD) begin
			mul_a = q_q;
		end else begin
			unique case (cmd.dsel)
				DOT_UV: begin
					mul_a = MW'(u_q[k2]);
					mul_b = MW'(v_q[k2]);
				end
				DOT_UU: begin
					mul_a = MW'(u_q[k2]);
					mul_b = MW'(u_q[k2]);
				end
				DOT_VV: begin
					mul_a = MW'(v_q[k2]);
					mul_b = MW'(v_q[k2]);
				end
				DOT_TT: begin
					mul_a = MW'(t_q[k2]);
					mul_b = MW'(t_q[k2]);
				end
				default: mul_a = '0;
			endcase
		end
	end

	assign prod    = mul_a * mul_b;
	assign dot_sum = acc_q + prod_s1;
	assign upd_cl  = clampc((PW+1)'(u_q[kp]) - (PW+1)'(prod_s1));

	assign mag = uv_q[DW-1] ? DW'(-uv_q) : DW'(uv_q);
	assign ge  = ({{(C-1){1'b0}}, r_q} >= ds_q);
	assign qm  = ovf_q ? {1'b1, {C{1'b0}}} : {1'b0, qmag_q};
	assign qpos = QW'(qm);
	assign qval = zero_q ? '0 :
		(neg_q ? (-qpos - QW'(r_q != '0)) : qpos);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			negc[i] = clampc(-((PW+1)'(v_q[i])));
			tcl[i]  = clampc((PW+1)'(t_q[i]));
		end
	end

	assign flags.uv_neg   = uv_q[DW-1];
	assign flags.uu_lt_vv = uu_q < vv_q;
	assign flags.vv_lt_uu = vv_q < uu_q;
	assign flags.d2_lt_vv = $signed({uv_q, 1'b0}) < (DW+1)'(vv_q);
	assign flags.vv_lt_tt = vv_q < tt_q;

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		unique case (cmd.op)
			OP_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i] <= in_a[i];
					v_q[i] <= in_b[i];
				end
			end
			OP_DOT: begin
				acc_q <= (cmd.idx == 2'd0) ? '0 : dot_sum;
				if (cmd.idx == 2'd3) begin
					unique case (cmd.dsel)
						DOT_UV: uv_q <= dot_sum;
						DOT_UU: uu_q <= dot_sum;
						DOT_VV: vv_q <= dot_sum;
						DOT_TT: tt_q <= dot_sum;
						default: uv_q <= dot_sum;
					endcase
				end
			end
			OP_NEGV: begin
				for (int i = 0; i < 3; i++) v_q[i] <= negc[i][C-1:0];
			end
			OP_SWAP: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i] <= v_q[i];
					v_q[i] <= u_q[i];
				end
				uu_q <= vv_q;
				vv_q <= uu_q;
			end
			OP_DIV_INIT: begin
				r_q    <= mag;
				neg_q  <= uv_q[DW-1];
				ds_q   <= {vv_q, {(C-1){1'b0}}};
				ovf_q  <= (mag >> C) >= DW'(vv_q);
				zero_q <= (vv_q == '0);
				qmag_q <= '0;
			end
			OP_DIV_STEP: begin
				if (ge) r_q <= r_q - ds_q[DW-1:0];
				qmag_q <= {qmag_q[C-2:0], ge};
				ds_q   <= ds_q >> 1;
			end
			OP_QFIX: q_q <= qval;
			OP_UPD: begin
				if (cmd.idx != 2'd0) t_q[kp] <= (C+1)'($signed(upd_cl[C-1:0]));
			end
			OP_ROT: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i] <= v_q[i];
					v_q[i] <= t_q[i][C-1:0];
				end
				uu_q <= vv_q;
			end
			OP_TDIFF: begin
				for (int i = 0; i < 3; i++) t_q[i] <= (C+1)'(u_q[i]) - (C+1)'(v_q[i]);
			end
			OP_FIN_A: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i] <= v_q[i];
					v_q[i] <= tcl[i][C-1:0];
				end
			end
			OP_FIN_B: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i] <= tcl[i][C-1:0];
					v_q[i] <= negc[i][C-1:0];
				end
			end
			OP_OUT: begin
				for (int i = 0; i < 3; i++) begin
					res_u_q[i] <= u_q[i];
					res_v_q[i] <= v_q[i];
				end
				res_st_q <= sat_q ? ST_SAT : (lim_q ? ST_LIMIT : ST_REDUCED);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
			lim_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					sat_q <= 1'b0;
					lim_q <= 1'b0;
				end
				OP_NEGV:   sat_q <= sat_q | negc[0][C] | negc[1][C] | negc[2][C];
				OP_UPD:    if (cmd.idx != 2'd0) sat_q <= sat_q | upd_cl[C];
				OP_SETLIM: lim_q <= flags.vv_lt_uu;
				OP_FIN_A:  sat_q <= sat_q | tcl[0][C] | tcl[1][C] | tcl[2][C];
				OP_FIN_B: begin
					sat_q <= sat_q | tcl[0][C] | tcl[1][C] | tcl[2][C]
						| negc[0][C] | negc[1][C] | negc[2][C];
				end
				default: ;
			endcase
		end
	end

	assign res_u      = res_u_q;
	assign res_v      = res_v_q;
	assign res_status = res_st_q;

	a_div_ovf_ds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DIV_STEP && ge) |-> ds_q[XW-1:DW] == '0)
		else $error("divider subtrahend wider than remainder");

	a_dd_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DIV_INIT) |-> !vv_q[DW-1])
		else $error("negative squared length");

	a_upd_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_UPD && cmd.idx != 2'd0 && upd_cl[C]) |=> sat_q)
		else $error("saturation not recorded");

endmodule

// ===== sv/gauss_lattice_basis_reduction_core.sv =====
// Gauss lattice basis reduction core: a beat carries two 3D fixed point
// vectors, the result beat carries the reduced pair and a status code.
// s_tdata fields from bit 0: a_x, a_y, a_z, b_x, b_y, b_z, each COORD_BITS
// signed, zero padded to whole bytes. m_tdata: first_x, first_y, first_z,
// second_x, second_y, second_z likewise; m_tuser holds status (0 reduced,
// 1 round limit reached, 2 coordinate saturated).
// One pair is worked at a time. Setup runs from the accept through three
// dot products, the sign fix and the ordering; each round holds two dot
// products on the single multiplier, a one-bit-per-cycle quotient divider
// with a setup and a fixup step, a vector update, the rotate and the loop
// test; then the closing step and an output load. The count of rounds,
// at most MAX_ROUNDS, sets how long a pair occupies the core.
// The result sits in an output register; a new beat is taken while it
// waits, and a stalled receiver only holds the next result back at the
// output load. Reset empties the output and returns to idle.
`timescale 1ns / 1ps

module gauss_lattice_basis_reduction_core import glbr_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int MAX_ROUNDS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z
	output logic [((6*COORD_BITS+7)/8)*8-1:0]     m_tdata,
	// status
	output logic [1:0]                            m_tuser
);

	localparam int C    = COORD_BITS;
	localparam int TD_W = ((6*COORD_BITS+7)/8)*8;

	logic signed [C-1:0] in_a [3];
	logic signed [C-1:0] in_b [3];
	logic signed [C-1:0] res_u [3];
	logic signed [C-1:0] res_v [3];
	logic [6*C-1:0]      res_bus;
	cmd_t                cmd;
	flags_t              flags;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_a[i] = s_tdata[i*C +: C];
			in_b[i] = s_tdata[(i+3)*C +: C];
			res_bus[i*C +: C]     = res_u[i];
			res_bus[(i+3)*C +: C] = res_v[i];
		end
	end

	assign m_tdata = TD_W'(res_bus);

	glbr_ctrl #(
		.COORD_BITS(COORD_BITS),
		.MAX_ROUNDS(MAX_ROUNDS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.flags   (flags),
		.cmd     (cmd)
	);

	glbr_dp #(
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_a      (in_a),
		.in_b      (in_b),
		.flags     (flags),
		.res_u     (res_u),
		.res_v     (res_v),
		.res_status(m_tuser)
	);

endmodule

// ===== tb/glbr_checker.sv =====
// checker for the lattice reduction core: predicts each reduced pair and compares result beats
`timescale 1ns / 1ps

module glbr_checker import glbr_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int MAX_ROUNDS = 64,
	parameter int DW = ((6*COORD_BITS+7)/8)*8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tready,
	input  logic [DW-1:0] s_tdata,
	input  logic          m_tvalid,
	input  logic          m_tready,
	input  logic [DW-1:0] m_tdata,
	input  logic [1:0]    m_tuser,
	output int            errors,
	output int            pending,
	output int            results_seen,
	output int            limit_seen,
	output int            sat_seen
);

	typedef logic signed [127:0] wide_t;
	typedef wide_t vec_t [3];

	localparam wide_t CMAX = (wide_t'(1) <<< (COORD_BITS-1)) - 1;
	localparam wide_t CMIN = -CMAX - 1;
	localparam wide_t QCAP = wide_t'(1) <<< 62;

	typedef struct {
		logic [DW-1:0] pair;
		logic [1:0]    status;
	} reduced_t;

	reduced_t reduced_q[$];

	function automatic wide_t dot3(vec_t p, vec_t r);
		return p[0]*r[0] + p[1]*r[1] + p[2]*r[2];
	endfunction

	function automatic wide_t clamp_coord(wide_t w, inout bit sat);
		if (w < CMIN) begin
			sat = 1;
			return CMIN;
		end
		if (w > CMAX) begin
			sat = 1;
			return CMAX;
		end
		return w;
	endfunction

	// floor of n/d, zero for a zero divisor
	function automatic wide_t floor_div(wide_t n, wide_t d);
		wide_t mag, qq, rr;
		bit neg;
		if (d == 0)
			return 0;
		neg = n < 0;
		mag = neg ? -n : n;
		qq = mag / d;
		rr = mag % d;
		if (qq > QCAP)
			qq = QCAP;
		if (neg) begin
			if (rr != 0)
				qq = qq + 1;
			qq = -qq;
		end
		return qq;
	endfunction

	function automatic reduced_t reduce_pair(logic [DW-1:0] d);
		vec_t u, v, t;
		wide_t q, tmp;
		bit sat, lim;
		int rounds;
		reduced_t r;
		sat = 0;
		lim = 0;
		rounds = 0;
		for (int i = 0; i < 3; i++) begin
			u[i] = $signed(d[i*COORD_BITS +: COORD_BITS]);
			v[i] = $signed(d[(3+i)*COORD_BITS +: COORD_BITS]);
		end
		if (dot3(u, v) < 0)
			for (int i = 0; i < 3; i++)
				v[i] = clamp_coord(-v[i], sat);
		if (dot3(u, u) < dot3(v, v)) begin
			t = u;
			u = v;
			v = t;
		end
		do begin
			q = floor_div(dot3(u, v), dot3(v, v));
			for (int i = 0; i < 3; i++) begin
				tmp = clamp_coord(u[i] - q*v[i], sat);
				u[i] = v[i];
				v[i] = tmp;
			end
			rounds++;
		end while (dot3(v, v) < dot3(u, u) && rounds < MAX_ROUNDS);
		if (dot3(v, v) < dot3(u, u))
			lim = 1;
		if (2*dot3(u, v) < dot3(v, v)) begin
			t = u;
			u = v;
			v = t;
		end else begin
			for (int i = 0; i < 3; i++)
				t[i] = u[i] - v[i];
			if (dot3(v, v) < dot3(t, t)) begin
				for (int i = 0; i < 3; i++) begin
					u[i] = v[i];
					v[i] = clamp_coord(t[i], sat);
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					u[i] = clamp_coord(t[i], sat);
					v[i] = clamp_coord(-v[i], sat);
				end
			end
		end
		r.pair = '0;
		for (int i = 0; i < 3; i++) begin
			r.pair[i*COORD_BITS +: COORD_BITS] = u[i][COORD_BITS-1:0];
			r.pair[(3+i)*COORD_BITS +: COORD_BITS] = v[i][COORD_BITS-1:0];
		end
		r.status = sat ? ST_SAT : (lim ? ST_LIMIT : ST_REDUCED);
		return r;
	endfunction

	task automatic report(string field, logic [DW-1:0] got, logic [DW-1:0] want);
		$display("%0t mismatch on %s: got %h expected %h", $realtime, field, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
		limit_seen = 0;
		sat_seen = 0;
	end

	always @(posedge clk) begin
		reduced_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				reduced_q.push_back(reduce_pair(s_tdata));
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (reduced_q.size() == 0) begin
					report("unexpected beat", m_tdata, '0);
				end else begin
					e = reduced_q.pop_front();
					if (e.status == ST_LIMIT)
						limit_seen++;
					if (e.status == ST_SAT)
						sat_seen++;
					for (int i = 0; i < 6; i++)
						if (m_tdata[i*COORD_BITS +: COORD_BITS] !=
						    e.pair[i*COORD_BITS +: COORD_BITS])
							report($sformatf("%s_%s", i < 3 ? "first" : "second",
								i % 3 == 0 ? "x" : (i % 3 == 1 ? "y" : "z")),
								m_tdata[i*COORD_BITS +: COORD_BITS],
								e.pair[i*COORD_BITS +: COORD_BITS]);
					if (m_tuser != e.status)
						report("status", m_tuser, e.status);
				end
			end
			pending = reduced_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the lattice reduction core: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

	localparam int CB = 24;
	localparam int DW = ((6*CB+7)/8)*8;
	localparam int LIMIT = 20000000;
	localparam logic signed [CB-1:0] PMAX = CB'((1 <<< (CB-1)) - 1);
	localparam logic signed [CB-1:0] PMIN = -PMAX - 1;

	logic          clk, arst_n;
	logic          s_tvalid, s_tready, m_tvalid, m_tready;
	logic [DW-1:0] s_tdata, m_tdata;
	logic [1:0]    m_tuser;
	int            errors, pending, results_seen, limit_seen, sat_seen;
	int            tx_idle, rx_idle, cycles, sent;
	bit            rx_hold;

	gauss_lattice_basis_reduction_core #(.COORD_BITS(CB), .MAX_ROUNDS(64)) dut (.*);

	glbr_checker #(.COORD_BITS(CB), .MAX_ROUNDS(64)) chk (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stall, or a long counted hold-off
	always @(negedge clk) begin
		int hold_cnt;
		if (rx_hold) begin
			m_tready <= 1'b0;
			hold_cnt++;
			if (hold_cnt >= 400) begin
				rx_hold = 0;
				hold_cnt = 0;
			end
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_beat(logic signed [CB-1:0] ax, ay, az, bx, by, bz);
		logic [DW-1:0] d;
		d = '0;
		d[0*CB +: CB] = ax;
		d[1*CB +: CB] = ay;
		d[2*CB +: CB] = az;
		d[3*CB +: CB] = bx;
		d[4*CB +: CB] = by;
		d[5*CB +: CB] = bz;
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			s_tdata  <= DW'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic signed [CB-1:0] rand_coord(int kind);
		case (kind)
			0: return CB'($urandom);
			1: return CB'($signed($urandom_range(2047)) - 1024);
			default: return CB'($signed($urandom_range(255)) - 128);
		endcase
	endfunction

	task automatic random_beat();
		logic signed [CB-1:0] x, y, z;
		int k, m, kind;
		kind = $urandom_range(9);
		if (kind < 4) begin
			send_beat(rand_coord(0), rand_coord(0), rand_coord(0),
				rand_coord(0), rand_coord(0), rand_coord(0));
		end else if (kind < 7) begin
			send_beat(rand_coord(1), rand_coord(1), rand_coord(1),
				rand_coord(1), rand_coord(1), rand_coord(1));
		end else if (kind < 9) begin
			// nearly collinear pair, long reductions
			x = rand_coord(2);
			y = rand_coord(2);
			z = rand_coord(2);
			k = $urandom_range(4000) + 1;
			m = $urandom_range(4000) + 1;
			send_beat(CB'(x*k + rand_coord(2)), CB'(y*k), CB'(z*k), CB'(x*m),
				CB'(y*m + $signed($urandom_range(3))), CB'(z*m));
		end else begin
			// exactly collinear, reaches a zero divisor
			x = rand_coord(2);
			y = rand_coord(2);
			z = rand_coord(2);
			k = $urandom_range(5000);
			m = $urandom_range(5000);
			send_beat(CB'(x*k), CB'(y*k), CB'(z*k), CB'(x*m), CB'(y*m), CB'(z*m));
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending != 0 || s_tvalid)
			@(negedge clk);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		rx_hold  = 0;
		cycles   = 0;
		sent     = 0;
		tx_idle  = 31;
		rx_idle  = 57;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zeros, extremes, sign fixup, ordering, saturation, collinear, long chains
		send_beat(0, 0, 0, 0, 0, 0);
		send_beat(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX);
		send_beat(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN);
		send_beat(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX);
		send_beat(PMAX, 0, 0, PMIN, 0, 0);
		send_beat(PMIN, 0, 0, 0, PMIN, 0);
		send_beat(4096, 0, 0, 0, 4096, 0);
		send_beat(4096, 0, 0, 0, 0, 0);
		send_beat(0, 0, 0, 0, 0, 4096);
		send_beat(100, 3, 0, -120, 5, 1);
		send_beat(1, 2, 3, 1000, 2001, 2999);
		send_beat(5702887, 3524578, 0, 3524578, 2178309, 0);
		send_beat(3524578, 2178309, 1, 5702887, 3524578, 0);
		send_beat(PMAX, PMAX - 1, 0, PMAX - 1, PMAX - 2, 0);
		send_beat(PMIN, PMAX, 0, PMAX, PMIN, 1);
		send_beat(12, 18, 6, 8, 12, 4);
		send_beat(-1, -1, -1, 1, 1, 1);
		send_beat(PMAX, PMIN, PMAX, PMIN, PMAX, PMIN);
		send_beat(-5, 7, -9, 6, -7, 8);
		send_beat(8388600, 1, 0, -8388600, 2, 0);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle = phase == 0 ? 31 : (phase == 1 ? 57 : 0);
			rx_idle = phase == 0 ? 57 : (phase == 1 ? 31 : 0);
			for (int n = 0; n < 660; n++) begin
				if (n == 100)
					rx_hold = 1;
				if (n == 300)
					wait_drained();
				random_beat();
			end
		end
		wait_drained();
		repeat (200) @(negedge clk);

		$display("sent %0d pairs, checked %0d reduced results", sent, results_seen);
		$display("round limit hit %0d times, saturation hit %0d times", limit_seen, sat_seen);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
